// ===== rtl/hvn_pkg.sv =====
`timescale 1ns / 1ps
package hvn_pkg;

   localparam int NORM_ONE = 16384;

   // Sequencer states.
   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_READ  = 14'b00000000000010,
      ST_DRAIN = 14'b00000000000100,
      ST_MULY  = 14'b00000000001000,
      ST_SQX   = 14'b00000000010000,
      ST_SQY   = 14'b00000000100000,
      ST_SQZ   = 14'b00000001000000,
      ST_L2    = 14'b00000010000000,
      ST_MID   = 14'b00000100000000,
      ST_T2    = 14'b00001000000000,
      ST_LOW   = 14'b00010000000000,
      ST_HIGH  = 14'b00100000000000,
      ST_CMP   = 14'b01000000000000,
      ST_DONE  = 14'b10000000000000
   } state_type;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   // Weights of one neighbor height in the x and z sums.
   typedef struct packed {
      logic              used;
      logic signed [3:0] cx;
      logic signed [3:0] cz;
   } coef_type;

   // Weights of the height at 3x3 position (pi,pj) around the vertex; mask
   // bit {dr,dc} marks cell (row-dr, col-dc) as inside the grid.
   function automatic coef_type cell_coef(input logic [1:0] pi, input logic [1:0] pj,
                                          input logic [3:0] mask);
      coef_type res;
      int       cx;
      int       cz;
      logic     u;
      cx = 0;
      cz = 0;
      u  = 1'b0;
      for (int ci = 0; ci < 4; ci++) begin
         int dr;
         int dc;
         int a;
         int b;
         dr = ci / 2;
         dc = ci % 2;
         a  = int'(pi) - 1 + dr;
         b  = int'(pj) - 1 + dc;
         if (mask[ci] && a >= 0 && a <= 1 && b >= 0 && b <= 1) begin
            u = 1'b1;
            if (!(dr == 1 && dc == 0)) begin
               if (a == 0 && b == 1) begin
                  cx = cx + 1;
                  cz = cz - 1;
               end
               if (a == 1 && b == 1) cx = cx - 1;
               if (a == 0 && b == 0) cz = cz + 1;
            end
            if (!(dr == 0 && dc == 1)) begin
               if (a == 0 && b == 0) cx = cx + 1;
               if (a == 1 && b == 0) begin
                  cx = cx - 1;
                  cz = cz + 1;
               end
               if (a == 1 && b == 1) cz = cz - 1;
            end
         end
      end
      res.used = u;
      res.cx   = 4'(cx);
      res.cz   = 4'(cz);
      return res;
   endfunction

   // Count of triangles touching the vertex.
   function automatic logic [2:0] face_count(input logic [3:0] mask);
      int n;
      n = 0;
      for (int ci = 0; ci < 4; ci++) begin
         if (mask[ci]) begin
            if (ci != 2) n = n + 1;
            if (ci != 1) n = n + 1;
         end
      end
      return 3'(n);
   endfunction

endpackage

// ===== rtl/hvn_ram.sv =====
`timescale 1ns / 1ps
module hvn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/heightfield_vertex_normals.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                  Handshake
// request   req_opcode req_row req_col req_height  start & !busy
// response  rsp_normal_x rsp_normal_y rsp_normal_z rsp_valid, one cycle, no stall
// config    csr_wdata                              csr_we
//
// A height write goes into the store at the accepting edge.
// A normal query holds busy while it runs on the single 30x20 multiplier: a read
// state for each of the nine neighbor positions, a drain, the squared length, then
// for each of three components a search of 14 or 15 steps plus a settle step, and
// a response; a zero-length sum skips the search.
// Reset is synchronous and leaves the store as is; rsp_valid is a one-cycle strobe.
module heightfield_vertex_normals #(
   parameter int GRID_SIZE = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_opcode,
   input  logic [5:0]          req_row,
   input  logic [5:0]          req_col,
   input  logic signed [15:0]  req_height,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_normal_x,
   output logic signed [15:0]  rsp_normal_y,
   output logic signed [15:0]  rsp_normal_z
);
   import hvn_pkg::*;

   localparam int CW = ($clog2(GRID_SIZE + 3) > 7) ? $clog2(GRID_SIZE + 3) : 7;
   localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);

   state_type         state_ff, state_in;
   logic [15:0]       cs_ff;
   logic [CW-1:0]     row_ff, row_in, col_ff, col_in;
   logic [3:0]        mask_ff, mask_in;
   logic [1:0]        pi_ff, pi_in, pj_ff, pj_in;
   logic              rd_valid_ff, rd_valid_in;
   coef_type          rd_coef_ff, rd_coef_in;
   logic signed [20:0] sx_ff, sx_in, sz_ff, sz_in;
   logic [19:0]       sy_ff, sy_in;
   logic [37:0]       sqx_ff, sqx_in, sqy_ff, sqy_in, sqz_ff, sqz_in;
   logic [39:0]       l2_ff, l2_in;
   logic [49:0]       prod_ff, prod_in;
   logic [29:0]       t2_ff, t2_in;
   logic [49:0]       acc_ff, acc_in;
   logic [14:0]       lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [1:0]        comp_ff, comp_in;
   logic signed [15:0] nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;

   logic [29:0]       mul_a;
   logic [19:0]       mul_b;
   logic              ram_we;
   logic [AW-1:0]     ram_addr;
   logic [15:0]       ram_rdata;
   logic [CW-1:0]     req_row_c, req_col_c, pr, pc;
   logic              req_in_grid, pos_in_grid;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [19:0]       mag_x, mag_z;
   logic [37:0]       c2;
   logic              c_neg;
   logic [14:0]       tt;
   logic [69:0]       tot, lim;
   logic [39:0]       l2_sum;
   logic signed [15:0] q_signed;
   logic signed [20:0] px, pz;

   hvn_ram #(.WIDTH(16), .DEPTH(GRID_SIZE * GRID_SIZE)) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_height),
      .rdata (ram_rdata)
   );

   // Request coordinates and write address.
   assign req_row_c   = {{(CW-6){1'b0}}, req_row};
   assign req_col_c   = {{(CW-6){1'b0}}, req_col};
   assign req_in_grid = (req_row_c < CW'(GRID_SIZE)) && (req_col_c < CW'(GRID_SIZE));
   assign wr_addr     = AW'(32'(req_row_c) * 32'(GRID_SIZE) + 32'(req_col_c));

   // Neighbor position row-1+pi, col-1+pj; held as row+pi so it stays unsigned.
   assign pr          = row_ff + CW'(pi_ff);
   assign pc          = col_ff + CW'(pj_ff);
   assign pos_in_grid = (pr >= CW'(1)) && (pr <= CW'(GRID_SIZE)) &&
                        (pc >= CW'(1)) && (pc <= CW'(GRID_SIZE));
   assign rd_addr     = AW'((32'(pr) - 32'd1) * 32'(GRID_SIZE) + 32'(pc) - 32'd1);

   // Write heights straight from the request port.
   assign ram_we   = start && !busy && (req_opcode == OP_WRITE) && req_in_grid;
   assign ram_addr = (state_ff == ST_READ) ? rd_addr : wr_addr;

   assign mag_x = sx_ff[20] ? 20'(-sx_ff) : 20'(sx_ff);
   assign mag_z = sz_ff[20] ? 20'(-sz_ff) : 20'(sz_ff);
   assign tt    = 15'(16'({mid_ff, 1'b0}) - 16'd1);
   assign l2_sum = 40'(sqx_ff) + 40'(sqy_ff) + 40'(prod_ff[37:0]);

   // Weighted neighbor height into the x and z sums.
   assign px = 21'($signed(ram_rdata)) * 21'(rd_coef_ff.cx);
   assign pz = 21'($signed(ram_rdata)) * 21'(rd_coef_ff.cz);

   // Pick the component under search.
   always_comb begin
      case (comp_ff)
         2'd0: begin
            c2    = sqx_ff;
            c_neg = sx_ff[20];
         end
         2'd1: begin
            c2    = sqy_ff;
            c_neg = 1'b0;
         end
         default: begin
            c2    = sqz_ff;
            c_neg = sz_ff[20];
         end
      endcase
   end

   assign q_signed = c_neg ? -16'(lo_ff) : 16'(lo_ff);
   assign tot      = 70'(acc_ff) + (70'(prod_ff) << 20);
   assign lim      = 70'(c2) << 30;

   // Shared multiplier operand select.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MULY: begin
            mul_a = 30'(face_count(mask_ff));
            mul_b = 20'(cs_ff);
         end
         ST_SQX: begin
            mul_a = 30'(mag_x);
            mul_b = mag_x;
         end
         ST_SQY: begin
            mul_a = 30'(sy_ff);
            mul_b = sy_ff;
         end
         ST_SQZ: begin
            mul_a = 30'(mag_z);
            mul_b = mag_z;
         end
         ST_T2: begin
            mul_a = 30'(tt);
            mul_b = 20'(tt);
         end
         ST_LOW: begin
            mul_a = prod_ff[29:0];
            mul_b = l2_ff[19:0];
         end
         ST_HIGH: begin
            mul_a = t2_ff;
            mul_b = l2_ff[39:20];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = 50'(mul_a) * 50'(mul_b);

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      mask_in     = mask_ff;
      pi_in       = pi_ff;
      pj_in       = pj_ff;
      rd_valid_in = 1'b0;
      rd_coef_in  = rd_coef_ff;
      sx_in       = sx_ff;
      sz_in       = sz_ff;
      sy_in       = sy_ff;
      sqx_in      = sqx_ff;
      sqy_in      = sqy_ff;
      sqz_in      = sqz_ff;
      l2_in       = l2_ff;
      t2_in       = t2_ff;
      acc_in      = acc_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      comp_in     = comp_ff;
      nx_in       = nx_ff;
      ny_in       = ny_ff;
      nz_in       = nz_ff;

      // Fold in the height read last cycle.
      if (rd_valid_ff) begin
         sx_in = sx_ff + px;
         sz_in = sz_ff + pz;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start && (req_opcode == OP_QUERY)) begin
               if (!req_in_grid) begin
                  // Off the grid: answer all zero.
                  nx_in    = '0;
                  ny_in    = '0;
                  nz_in    = '0;
                  state_in = ST_DONE;
               end else begin
                  row_in  = req_row_c;
                  col_in  = req_col_c;
                  // Mark the cells of the vertex that lie inside the grid.
                  for (int ci = 0; ci < 4; ci++) begin
                     mask_in[ci] = (req_row_c >= CW'(ci / 2)) &&
                                   (req_col_c >= CW'(ci % 2)) &&
                                   (req_row_c + CW'(2) <= CW'(GRID_SIZE) + CW'(ci / 2)) &&
                                   (req_col_c + CW'(2) <= CW'(GRID_SIZE) + CW'(ci % 2));
                  end
                  pi_in    = '0;
                  pj_in    = '0;
                  sx_in    = '0;
                  sz_in    = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // Issue one neighbor read; skip those no triangle uses.
            rd_coef_in  = cell_coef(pi_ff, pj_ff, mask_ff);
            rd_valid_in = pos_in_grid && rd_coef_in.used;
            if (pj_ff == 2'd2) begin
               pj_in = '0;
               pi_in = pi_ff + 2'd1;
               if (pi_ff == 2'd2) state_in = ST_DRAIN;
            end else begin
               pj_in = pj_ff + 2'd1;
            end
         end
         ST_DRAIN: state_in = ST_MULY;
         ST_MULY:  state_in = ST_SQX;
         ST_SQX: begin
            sy_in    = prod_ff[19:0];
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sqx_in   = prod_ff[37:0];
            state_in = ST_SQZ;
         end
         ST_SQZ: begin
            sqy_in   = prod_ff[37:0];
            state_in = ST_L2;
         end
         ST_L2: begin
            sqz_in = prod_ff[37:0];
            l2_in  = l2_sum;
            if (l2_sum == '0) begin
               // Degenerate sum: point straight up.
               nx_in    = '0;
               ny_in    = 16'(NORM_ONE);
               nz_in    = '0;
               state_in = ST_DONE;
            end else begin
               comp_in  = '0;
               lo_in    = '0;
               hi_in    = 15'(NORM_ONE);
               state_in = ST_MID;
            end
         end
         ST_MID: begin
            if (lo_ff == hi_ff) begin
               // Search settled: store this component, move to the next.
               case (comp_ff)
                  2'd0:    nx_in = q_signed;
                  2'd1:    ny_in = q_signed;
                  default: nz_in = q_signed;
               endcase
               lo_in = '0;
               hi_in = 15'(NORM_ONE);
               if (comp_ff == 2'd2) begin
                  state_in = ST_DONE;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end else begin
               mid_in   = 15'((16'(lo_ff) + 16'(hi_ff) + 16'd1) >> 1);
               state_in = ST_T2;
            end
         end
         ST_T2: state_in = ST_LOW;
         ST_LOW: begin
            t2_in    = prod_ff[29:0];
            state_in = ST_HIGH;
         end
         ST_HIGH: begin
            acc_in   = prod_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // Keep mid when (2mid-1)^2 * L2 <= 2^30 * c^2.
            if (tot <= lim) lo_in = mid_ff;
            else            hi_in = mid_ff - 15'd1;
            state_in = ST_MID;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cs_ff       <= 16'd256;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
         if (csr_we) cs_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      col_ff     <= col_in;
      mask_ff    <= mask_in;
      pi_ff      <= pi_in;
      pj_ff      <= pj_in;
      rd_coef_ff <= rd_coef_in;
      sx_ff      <= sx_in;
      sz_ff      <= sz_in;
      sy_ff      <= sy_in;
      sqx_ff     <= sqx_in;
      sqy_ff     <= sqy_in;
      sqz_ff     <= sqz_in;
      l2_ff      <= l2_in;
      prod_ff    <= prod_in;
      t2_ff      <= t2_in;
      acc_ff     <= acc_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      comp_ff    <= comp_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      nz_ff      <= nz_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_DONE);
   assign rsp_normal_x = nx_ff;
   assign rsp_normal_y = ny_ff;
   assign rsp_normal_z = nz_ff;

   // The response strobe is never held high.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe held");

   // Store writes happen only while idle.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !busy) else $error("store write while busy");

   // The search interval never inverts.
   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MID) |-> (lo_ff <= hi_ff)) else $error("search bounds crossed");

   // A query result follows the search or an early exit, never a write.
   a_done_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> ($past(state_ff) == ST_MID || $past(state_ff) == ST_L2 ||
                                 $past(state_ff) == ST_IDLE))
      else $error("response from unexpected state");

endmodule

// ===== verif/heightfield_vertex_normals_test.sv =====
`timescale 1ns / 1ps
module heightfield_vertex_normals_test;
   import hvn_pkg::*;

   localparam int GRID       = 64;
   localparam int CYCLE_CAP  = 2000000;
   localparam int QUERY_WAIT = 300;

   typedef struct {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
   } normal_type;

   // Scoreboard: own copy of the height store and grid spacing, plus the
   // normals still owed by the block, oldest first.
   class normal_scoreboard;
      logic [15:0] heights [GRID*GRID];
      logic [15:0] grid_step;
      normal_type  owed [$];
      int          mismatches;

      function new();
         grid_step  = 16'd256;
         mismatches = 0;
         foreach (heights[i]) heights[i] = 16'd0;
      endfunction

      function int hgt(int r, int c);
         return int'($signed(heights[r*GRID + c]));
      endfunction

      // Magnitude of one component: largest q in [0,16384] with
      // (2q-1)^2 * L2 <= 2^30 * c^2, then give it the sign of c.
      function logic signed [15:0] unit_part(longint comp, longint unsigned l2);
         longint unsigned mag;
         logic [127:0]    rhs;
         logic [127:0]    lhs;
         int unsigned     lo;
         int unsigned     hi;
         int unsigned     mid;
         longint unsigned t;
         mag = (comp < 0) ? longint'(-comp) : longint'(comp);
         rhs = 128'(mag * mag) << 30;
         lo  = 0;
         hi  = NORM_ONE;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t   = 2 * longint'(mid) - 1;
            lhs = 128'(t * t) * 128'(l2);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
         end
         return (comp < 0) ? -16'(lo) : 16'(lo);
      endfunction

      function normal_type vertex_normal(int row, int col);
         normal_type      n;
         longint          sx;
         longint          sy;
         longint          sz;
         int              faces;
         int              r;
         int              c;
         longint          h00;
         longint          h01;
         longint          h10;
         longint          h11;
         longint unsigned l2;
         sx    = 0;
         sz    = 0;
         faces = 0;
         for (int dr = 0; dr < 2; dr++) begin
            for (int dc = 0; dc < 2; dc++) begin
               r = row - dr;
               c = col - dc;
               if (r >= 0 && c >= 0 && r + 2 <= GRID && c + 2 <= GRID) begin
                  h00 = hgt(r, c);
                  h01 = hgt(r, c + 1);
                  h10 = hgt(r + 1, c);
                  h11 = hgt(r + 1, c + 1);
                  // upper triangle of the cell
                  if (!(dr == 1 && dc == 0)) begin
                     sx += h01 - h11;
                     sz += h00 - h01;
                     faces++;
                  end
                  // lower triangle of the cell
                  if (!(dr == 0 && dc == 1)) begin
                     sx += h00 - h10;
                     sz += h10 - h11;
                     faces++;
                  end
               end
            end
         end
         sy = longint'(faces) * longint'(grid_step);
         l2 = longint'(sx*sx) + longint'(sy*sy) + longint'(sz*sz);
         if (l2 == 0) begin
            // flat field with zero spacing: straight up
            n.nx = 0;
            n.ny = 16'(NORM_ONE);
            n.nz = 0;
         end else begin
            n.nx = unit_part(sx, l2);
            n.ny = unit_part(sy, l2);
            n.nz = unit_part(sz, l2);
         end
         return n;
      endfunction

      function void note_request(opcode_type op, int row, int col, logic [15:0] h);
         if (op == OP_WRITE) heights[row*GRID + col] = h;
         else owed.insert(owed.size(), vertex_normal(row, col));
      endfunction

      function void report_mismatch(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endfunction

      function void check_response(logic signed [15:0] x, logic signed [15:0] y,
                                   logic signed [15:0] z);
         normal_type e;
         if (owed.size() == 0) begin
            report_mismatch($sformatf("unexpected normal (%0d,%0d,%0d)", x, y, z));
            return;
         end
         e = owed.pop_front();
         if (x !== e.nx) report_mismatch($sformatf("normal_x %0d, want %0d", x, e.nx));
         if (y !== e.ny) report_mismatch($sformatf("normal_y %0d, want %0d", y, e.ny));
         if (z !== e.nz) report_mismatch($sformatf("normal_z %0d, want %0d", z, e.nz));
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_opcode = 1'b0;
   logic [5:0]         req_row = '0;
   logic [5:0]         req_col = '0;
   logic signed [15:0] req_height = '0;
   logic               csr_we = 1'b0;
   logic [15:0]        csr_wdata = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic signed [15:0] rsp_normal_z;

   normal_scoreboard sb = new();
   bit               written [GRID*GRID];
   int               sent;
   bit               no_gaps;
   int               cycles;

   heightfield_vertex_normals #(.GRID_SIZE(GRID)) i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_height   (req_height),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_normal_x (rsp_normal_x),
      .rsp_normal_y (rsp_normal_y),
      .rsp_normal_z (rsp_normal_z)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Results cannot be held off: check every strobe as it goes by.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_normal_x, rsp_normal_y, rsp_normal_z);
   end

   // Heights lean toward the extremes so steep slopes show up often.
   function logic [15:0] pick_height();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'($urandom_range(0, 64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   // Present one request and hold it until the block takes it. Called at
   // a clock edge; returns at the edge of acceptance. An idle stretch waits
   // out any busy time first, so the block really sits ready with start low.
   task automatic send(opcode_type op, int row, int col, logic [15:0] h);
      if (!no_gaps && $urandom_range(0, 99) < 26) begin
         start <= 1'b0;
         do @(posedge clock); while (busy);
         while ($urandom_range(0, 99) < 26) @(posedge clock);
      end
      start      <= 1'b1;
      req_opcode <= op;
      req_row    <= 6'(row);
      req_col    <= 6'(col);
      req_height <= h;
      do @(posedge clock); while (busy);
      sb.note_request(op, row, col, h);
      if (op == OP_WRITE) written[row*GRID + col] = 1'b1;
      sent++;
   endtask

   task automatic write_height(int row, int col, logic [15:0] h);
      send(OP_WRITE, row, col, h);
   endtask

   // Fill any unwritten neighbor first, so the query never reads an
   // empty store entry, then ask for the normal.
   task automatic query(int row, int col);
      for (int r = row - 1; r <= row + 1; r++)
         for (int c = col - 1; c <= col + 1; c++)
            if (r >= 0 && c >= 0 && r < GRID && c < GRID && !written[r*GRID + c])
               write_height(r, c, pick_height());
      send(OP_QUERY, row, col, 16'($urandom));
   endtask

   // Drain all owed normals, let the block settle, then change the spacing.
   task automatic set_cell_size(logic [15:0] value);
      start <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (QUERY_WAIT) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.grid_step = value;
      @(posedge clock);
   endtask

   task automatic random_run(int count);
      int goal;
      int r;
      int c;
      goal = sent + count;
      while (sent < goal) begin
         r = $urandom_range(0, GRID - 1);
         c = $urandom_range(0, GRID - 1);
         // bias toward the border now and then
         if ($urandom_range(0, 9) == 0) r = ($urandom_range(0, 1) != 0) ? GRID - 1 : 0;
         if ($urandom_range(0, 9) == 0) c = ($urandom_range(0, 1) != 0) ? GRID - 1 : 0;
         if ($urandom_range(0, 99) < 35) write_height(r, c, pick_height());
         else query(r, c);
      end
   endtask

   initial begin
      logic [15:0] spacing;
      cycles  = 0;
      sent    = 0;
      no_gaps = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: corners, edges, interior, extreme heights.
      set_cell_size(16'd256);
      write_height(0, 0, 16'h7fff);
      write_height(0, 1, 16'h8000);
      write_height(1, 0, 16'h8000);
      write_height(1, 1, 16'h7fff);
      query(0, 0);
      query(GRID - 1, GRID - 1);
      query(0, GRID - 1);
      query(GRID - 1, 0);
      query(0, 20);
      query(31, 0);
      write_height(32, 32, 16'h8000);
      query(32, 32);
      query(33, 33);
      write_height(32, 32, 16'h7fff);
      query(32, 32);

      set_cell_size(16'd1);
      random_run(70);
      set_cell_size(16'hffff);
      random_run(70);

      // Zero spacing: a flat patch gives the straight-up special case.
      set_cell_size(16'd0);
      for (int r = 10; r <= 12; r++)
         for (int c = 10; c <= 12; c++)
            write_height(r, c, 16'h0123);
      query(11, 11);
      random_run(20);

      spacing = 16'($urandom_range(1, 65535));
      set_cell_size(spacing);
      no_gaps = 1'b1;
      random_run(100);
      no_gaps = 1'b0;
      set_cell_size(16'($urandom));
      random_run(100);
      set_cell_size(16'd256);
      random_run(100);

      start <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (QUERY_WAIT) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/hvn_pkg.sv
rtl/hvn_ram.sv
rtl/heightfield_vertex_normals.sv
verif/heightfield_vertex_normals_test.sv
